FILE: hw/rtl/sps_pkg.sv
// Shared types and constants of the segmented prime sieve.
`default_nettype none

package sps_pkg;

  // Cap on the number of results of one request.
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Smallest prime; also the first value that can survive the sieve.
  localparam int FIRST_PRIME = 2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ERR,
    ST_SQRT,
    ST_BINIT,
    ST_BPREP,
    ST_BOUT,
    ST_BCHK,
    ST_BSTRIKE,
    ST_SINIT,
    ST_PPREP,
    ST_POUT,
    ST_PCHK,
    ST_PDIV,
    ST_PSTRIKE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT,
    ST_FINAL
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQRT_STEP,
    OP_P_ZERO,
    OP_BINIT_WR,
    OP_P_TWO,
    OP_P_NEXT,
    OP_J_PSQ,
    OP_BSTRIKE,
    OP_K_ZERO,
    OP_SINIT_WR,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_J_DIV,
    OP_PSTRIKE,
    OP_SCAN_INIT,
    OP_TAKE,
    OP_K_NEXT
  } dp_op_t;

  typedef enum logic [1:0] {
    OUT_PRIME,
    OUT_FINAL,
    OUT_ERR
  } out_sel_t;

  typedef struct packed {
    dp_op_t   op;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic sqrt_done;
    logic binit_last;
    logic bout_done;
    logic base_mark;
    logic bstrike_done;
    logic k_last;
    logic pout_done;
    logic psq_ge_lo;
    logic div_done;
    logic pstrike_done;
    logic seg_mark;
    logic have_pend;
    logic cap_hit;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sps_if.sv
// Request and result channel interfaces of the segmented prime sieve.
`default_nettype none

interface sps_req_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] low_bound;
  logic [W-1:0] high_bound;

  modport source (output valid, low_bound, high_bound, input ready);
  modport sink   (input valid, low_bound, high_bound, output ready);
endinterface

interface sps_res_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] prime_value;
  logic         found;
  logic         range_error;
  logic         last;

  modport source (output valid, prime_value, found, range_error, last, input ready);
  modport sink   (input valid, prime_value, found, range_error, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sps_ctrl.sv
// Sequencing state machine of the segmented prime sieve.
`default_nettype none

module sps_ctrl
  import sps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state, state_next;
  logic   scan_stop;

  // The scan ends at the last segment entry or once the result cap is reached.
  assign scan_stop = stat.k_last || stat.cap_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_CHECK;
      ST_CHECK:    state_next = stat.err ? ST_ERR : ST_SQRT;
      ST_ERR:      if (out_ready) state_next = ST_IDLE;
      ST_SQRT:     if (stat.sqrt_done) state_next = ST_BINIT;
      ST_BINIT:    if (stat.binit_last) state_next = ST_BPREP;
      ST_BPREP:    state_next = ST_BOUT;
      ST_BOUT:     state_next = stat.bout_done ? ST_SINIT : ST_BCHK;
      ST_BCHK:     state_next = stat.base_mark ? ST_BSTRIKE : ST_BOUT;
      ST_BSTRIKE:  if (stat.bstrike_done) state_next = ST_BOUT;
      ST_SINIT:    if (stat.k_last) state_next = ST_PPREP;
      ST_PPREP:    state_next = ST_POUT;
      ST_POUT:     state_next = stat.pout_done ? ST_SCAN_RD : ST_PCHK;
      ST_PCHK: begin
        if (!stat.base_mark) begin
          state_next = ST_POUT;
        end else if (stat.psq_ge_lo) begin
          state_next = ST_PSTRIKE;
        end else begin
          state_next = ST_PDIV;
        end
      end
      ST_PDIV:     if (stat.div_done) state_next = ST_PSTRIKE;
      ST_PSTRIKE:  if (stat.pstrike_done) state_next = ST_POUT;
      ST_SCAN_RD:  state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (stat.seg_mark && stat.have_pend) begin
          state_next = ST_EMIT;
        end else if (stat.seg_mark) begin
          state_next = scan_stop ? ST_FINAL : ST_SCAN_RD;
        end else begin
          state_next = stat.k_last ? ST_FINAL : ST_SCAN_RD;
        end
      end
      ST_EMIT:     if (out_ready) state_next = scan_stop ? ST_FINAL : ST_SCAN_RD;
      ST_FINAL:    if (out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.op      = OP_NOP;
    cmd.out_sel = OUT_PRIME;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_CHECK: cmd.op = OP_NOP;
      ST_ERR: begin
        out_valid   = 1'b1;
        cmd.out_sel = OUT_ERR;
      end
      ST_SQRT:    cmd.op = stat.sqrt_done ? OP_P_ZERO : OP_SQRT_STEP;
      ST_BINIT:   cmd.op = OP_BINIT_WR;
      ST_BPREP:   cmd.op = OP_P_TWO;
      ST_BOUT:    cmd.op = stat.bout_done ? OP_K_ZERO : OP_NOP;
      ST_BCHK:    cmd.op = stat.base_mark ? OP_J_PSQ : OP_P_NEXT;
      ST_BSTRIKE: cmd.op = stat.bstrike_done ? OP_P_NEXT : OP_BSTRIKE;
      ST_SINIT:   cmd.op = OP_SINIT_WR;
      ST_PPREP:   cmd.op = OP_P_TWO;
      ST_POUT:    cmd.op = stat.pout_done ? OP_SCAN_INIT : OP_NOP;
      ST_PCHK: begin
        if (!stat.base_mark) begin
          cmd.op = OP_P_NEXT;
        end else if (stat.psq_ge_lo) begin
          cmd.op = OP_J_PSQ;
        end else begin
          cmd.op = OP_DIV_START;
        end
      end
      ST_PDIV:    cmd.op = stat.div_done ? OP_J_DIV : OP_DIV_STEP;
      ST_PSTRIKE: cmd.op = stat.pstrike_done ? OP_P_NEXT : OP_PSTRIKE;
      ST_SCAN_RD: cmd.op = OP_NOP;
      ST_SCAN_CHK: begin
        if (stat.seg_mark && !stat.have_pend) begin
          cmd.op = OP_TAKE;
        end else if (!stat.seg_mark) begin
          cmd.op = OP_K_NEXT;
        end
      end
      ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.out_sel = OUT_PRIME;
        if (out_ready) cmd.op = OP_TAKE;
      end
      ST_FINAL: begin
        out_valid   = 1'b1;
        cmd.out_sel = OUT_FINAL;
      end
      default: cmd.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sps_datapath.sv
// Datapath of the segmented prime sieve: counters, bit stores and remainder unit.
`default_nettype none

module sps_datapath
  import sps_pkg::*;
#(
  parameter int VALUE_BITS   = 16,
  parameter int SEGMENT_SIZE = 64,
  parameter int BASE_LIMIT   = 256
) (
  input  wire logic                  clk,
  input  wire dp_cmd_t               cmd,
  input  wire logic [VALUE_BITS-1:0] lo_in,
  input  wire logic [VALUE_BITS-1:0] hi_in,
  output dp_stat_t                   stat,
  output logic [VALUE_BITS-1:0]      prime_value,
  output logic                       found,
  output logic                       range_error,
  output logic                       last
);

  localparam int V    = VALUE_BITS;
  localparam int IB   = $clog2(BASE_LIMIT);
  localparam int PW   = IB + 1;
  localparam int WW   = ((V > 2 * PW) ? V : 2 * PW) + 1;
  localparam int KW   = $clog2(SEGMENT_SIZE);
  localparam int CMPW = V + 12;
  localparam int DW   = $clog2(V + 1);

  logic [V-1:0]     lo, hi;
  logic [IB-1:0]    bound;
  logic [WW-1:0]    sq;
  logic [PW-1:0]    p;
  logic [WW-1:0]    psq;
  logic [WW-1:0]    j;
  logic [KW-1:0]    k;
  logic [PW-1:0]    rem;
  logic [V-1:0]     dsh;
  logic [DW-1:0]    dcnt;
  logic [V-1:0]     pend;
  logic             have_pend;
  logic [CNT_W-1:0] count;

  logic             base_mem [BASE_LIMIT];
  logic             seg_mem  [SEGMENT_SIZE];
  logic             base_rd, seg_rd;
  logic             base_we, base_wd, seg_we, seg_wd;
  logic [IB-1:0]    base_wa;
  logic [KW-1:0]    seg_wa;

  logic [V:0]       diff;
  logic [KW-1:0]    span_m1;
  logic [PW:0]      rem_shift;
  logic [PW:0]      rem_sub;
  logic [WW-1:0]    j_off;

  assign diff      = {1'b0, hi} - {1'b0, lo};
  assign span_m1   = KW'(diff[V-1:0]);
  assign rem_shift = {rem, dsh[V-1]};
  assign rem_sub   = rem_shift - {1'b0, p};
  assign j_off     = j - WW'(lo);

  always_comb begin
    stat.err          = diff[V] || (CMPW'(diff[V-1:0]) > CMPW'(SEGMENT_SIZE - 1));
    stat.sqrt_done    = (sq > WW'(hi)) || (bound == IB'(BASE_LIMIT - 1));
    stat.binit_last   = (p == PW'(bound));
    stat.bout_done    = (psq > WW'(bound));
    stat.base_mark    = base_rd;
    stat.bstrike_done = (j > WW'(bound));
    stat.k_last       = (k == span_m1);
    stat.pout_done    = (p > PW'(bound));
    stat.psq_ge_lo    = (psq >= WW'(lo));
    stat.div_done     = (dcnt == '0);
    stat.pstrike_done = (j > WW'(hi));
    stat.seg_mark     = seg_rd;
    stat.have_pend    = have_pend;
    stat.cap_hit      = (count == CNT_W'(MAX_RESULTS - 1));
  end

  always_comb begin
    base_we = 1'b0;
    base_wa = p[IB-1:0];
    base_wd = 1'b0;
    seg_we  = 1'b0;
    seg_wa  = k;
    seg_wd  = 1'b0;
    unique case (cmd.op)
      OP_BINIT_WR: begin
        base_we = 1'b1;
        base_wd = (p >= PW'(FIRST_PRIME));
      end
      OP_BSTRIKE: begin
        base_we = 1'b1;
        base_wa = j[IB-1:0];
      end
      OP_SINIT_WR: begin
        seg_we = 1'b1;
        seg_wd = ((WW'(lo) + WW'(k)) >= WW'(FIRST_PRIME));
      end
      OP_PSTRIKE: begin
        seg_we = 1'b1;
        seg_wa = KW'(j_off);
      end
      default: ;
    endcase
  end

  // Both stores are read every cycle; the read data is ready in the following state.
  always_ff @(posedge clk) begin
    if (base_we) base_mem[base_wa] <= base_wd;
    base_rd <= base_mem[p[IB-1:0]];
  end

  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[seg_wa] <= seg_wd;
    seg_rd <= seg_mem[k];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        lo    <= lo_in;
        hi    <= hi_in;
        bound <= '0;
        sq    <= WW'(1);
      end
      // sq tracks (bound + 1) squared.
      OP_SQRT_STEP: begin
        bound <= bound + IB'(1);
        sq    <= sq + (WW'(bound) << 1) + WW'(3);
      end
      OP_P_ZERO: p <= '0;
      OP_BINIT_WR: p <= p + PW'(1);
      OP_P_TWO: begin
        p   <= PW'(FIRST_PRIME);
        psq <= WW'(FIRST_PRIME * FIRST_PRIME);
      end
      OP_P_NEXT: begin
        p   <= p + PW'(1);
        psq <= psq + (WW'(p) << 1) + WW'(1);
      end
      OP_J_PSQ: j <= psq;
      OP_BSTRIKE, OP_PSTRIKE: j <= j + WW'(p);
      OP_K_ZERO: k <= '0;
      OP_SINIT_WR: k <= k + KW'(1);
      OP_DIV_START: begin
        rem  <= '0;
        dsh  <= lo;
        dcnt <= DW'(V);
      end
      // Restoring remainder, one bit of the low bound per cycle.
      OP_DIV_STEP: begin
        rem  <= rem_sub[PW] ? PW'(rem_shift) : PW'(rem_sub);
        dsh  <= dsh << 1;
        dcnt <= dcnt - DW'(1);
      end
      OP_J_DIV: j <= WW'(lo) + ((rem == '0) ? WW'(0) : WW'(p - rem));
      OP_SCAN_INIT: begin
        k         <= '0;
        have_pend <= 1'b0;
        count     <= '0;
      end
      OP_TAKE: begin
        pend      <= lo + V'(k);
        have_pend <= 1'b1;
        count     <= count + CNT_W'(1);
        k         <= k + KW'(1);
      end
      OP_K_NEXT: k <= k + KW'(1);
      default: ;
    endcase
  end

  always_comb begin
    prime_value = '0;
    found       = 1'b0;
    range_error = 1'b0;
    last        = 1'b0;
    unique case (cmd.out_sel)
      OUT_PRIME: begin
        prime_value = pend;
        found       = 1'b1;
      end
      OUT_FINAL: begin
        prime_value = have_pend ? pend : '0;
        found       = have_pend;
        last        = 1'b1;
      end
      OUT_ERR: begin
        range_error = 1'b1;
        last        = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/segmented_prime_sieve_core.sv
// Segmented prime sieve: one request in, the primes of [low, high] out in order.
// A rejected request is answered from an error state after a check state. A valid one runs a
// square-root walk, a base-store fill and strike, a segment fill, a check of each base
// value, a remainder for each base prime whose square lies below the low bound and the strikes
// per base prime, then a scan of the segment entries, the work lying mostly in the remainders.
// One request at a time; synchronous reset returns to idle.
`default_nettype none

module segmented_prime_sieve_core
  import sps_pkg::*;
#(
  parameter int SEGMENT_SIZE = 64,
  parameter int VALUE_BITS   = 16,
  parameter int BASE_LIMIT   = 256
) (
  input wire logic clk,
  input wire logic rst,
  sps_req_if.sink   req,
  sps_res_if.source res
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sps_datapath #(
    .VALUE_BITS   (VALUE_BITS),
    .SEGMENT_SIZE (SEGMENT_SIZE),
    .BASE_LIMIT   (BASE_LIMIT)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .lo_in       (req.low_bound),
    .hi_in       (req.high_bound),
    .stat        (stat),
    .prime_value (res.prime_value),
    .found       (res.found),
    .range_error (res.range_error),
    .last        (res.last)
  );

  // No new request is taken while results of the current one are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !req.ready)
    else $error("request taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("ready stayed high after a request was taken");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.range_error) |-> (res.last && !res.found))
    else $error("range error result is not a lone final result");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.found) |-> res.last)
    else $error("result without a prime is not the final one");

endmodule

`default_nettype wire

FILE: test/segmented_prime_sieve_core_tb.sv
// Self-checking testbench of the segmented prime sieve core with a built-in prime predictor.
`default_nettype none

module segmented_prime_sieve_core_tb
  import sps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEGMENT_SIZE = 64;
  localparam int VALUE_BITS   = 16;
  localparam int BASE_LIMIT   = 256;
  localparam int TIMEOUT_CYCLES = 5_000_000;
  localparam int DRAIN_CYCLES   = 3000;
  localparam int IDLE_PCT       = 26;
  localparam int CALM_START     = 30_000;
  localparam int CALM_END       = 90_000;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  found;
    logic                  range_error;
    logic                  last;
  } prime_result_t;

  typedef struct {
    logic [VALUE_BITS-1:0] low_bound;
    logic [VALUE_BITS-1:0] high_bound;
    bit                    hold;
  } range_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sps_req_if #(.W(VALUE_BITS)) req_ch ();
  sps_res_if #(.W(VALUE_BITS)) res_ch ();

  segmented_prime_sieve_core #(
    .SEGMENT_SIZE(SEGMENT_SIZE),
    .VALUE_BITS  (VALUE_BITS),
    .BASE_LIMIT  (BASE_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  always #1 clk = ~clk;

  range_req_t    pending_ranges[$];
  prime_result_t expected_primes[$];
  prime_result_t got_result;
  prime_result_t want_result;
  range_req_t    next_range;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            ranges_taken = 0;
  int            ranges_answered = 0;
  bit            calm;

  assign calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

  // Appends the expected results of one range, in the order the block emits them.
  task automatic predict_primes(input logic [VALUE_BITS-1:0] low_in,
                                input logic [VALUE_BITS-1:0] high_in);
    bit            base_mark[BASE_LIMIT];
    bit            seg_mark[SEGMENT_SIZE];
    prime_result_t primes_q[$];
    prime_result_t entry;
    int unsigned   lo, hi, span, root, i, j, p, start;
    lo = low_in;
    hi = high_in;
    if (hi < lo || hi - lo + 1 > SEGMENT_SIZE) begin
      entry = '{value: '0, found: 1'b0, range_error: 1'b1, last: 1'b1};
      expected_primes = {expected_primes, entry};
      return;
    end
    span = hi - lo + 1;
    root = 0;
    while ((root + 1) * (root + 1) <= hi) root++;
    if (root > BASE_LIMIT - 1) root = BASE_LIMIT - 1;
    for (i = 0; i <= root; i++) base_mark[i] = (i >= FIRST_PRIME);
    for (i = FIRST_PRIME; i * i <= root; i++) begin
      if (base_mark[i]) begin
        for (j = i * i; j <= root; j += i) base_mark[j] = 1'b0;
      end
    end
    for (i = 0; i < span; i++) seg_mark[i] = (lo + i >= FIRST_PRIME);
    for (p = FIRST_PRIME; p <= root; p++) begin
      if (base_mark[p]) begin
        start = (lo / p) * p;
        if (start < lo) start += p;
        if (start < p * p) start = p * p;
        for (j = start; j <= hi; j += p) seg_mark[j - lo] = 1'b0;
      end
    end
    for (i = 0; i < span && primes_q.size() < MAX_RESULTS; i++) begin
      if (seg_mark[i]) begin
        entry = '{value: VALUE_BITS'(lo + i), found: 1'b1, range_error: 1'b0, last: 1'b0};
        primes_q = {primes_q, entry};
      end
    end
    if (primes_q.size() == 0) begin
      entry = '{value: '0, found: 1'b0, range_error: 1'b0, last: 1'b1};
      primes_q = {primes_q, entry};
    end
    primes_q[primes_q.size() - 1].last = 1'b1;
    foreach (primes_q[k]) expected_primes = {expected_primes, primes_q[k]};
  endtask

  task automatic add_range(input int unsigned lo, input int unsigned hi, input bit hold);
    range_req_t r;
    r.low_bound  = VALUE_BITS'(lo);
    r.high_bound = VALUE_BITS'(hi);
    r.hold       = hold;
    pending_ranges = {pending_ranges, r};
  endtask

  task automatic note_mismatch(input string what, input prime_result_t want,
                               input prime_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"%0t: %s: expected value=%0d found=%0b err=%0b last=%0b,",
                " got value=%0d found=%0b err=%0b last=%0b"},
               $realtime, what, want.value, want.found, want.range_error, want.last,
               got.value, got.found, got.range_error, got.last);
  endtask

  // Driver: a request stays up until taken; a held request waits for the block to drain.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid      <= 1'b0;
      req_ch.low_bound  <= '0;
      req_ch.high_bound <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_ranges.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
          (!pending_ranges[0].hold ||
           (!req_ch.valid && ranges_taken == ranges_answered))) begin
        next_range = pending_ranges.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.low_bound  <= next_range.low_bound;
        req_ch.high_bound <= next_range.high_bound;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks results first, then predicts any request taken at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready    <= 1'b0;
      ranges_taken    <= 0;
      ranges_answered <= 0;
    end else begin
      res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (res_ch.valid && res_ch.ready) begin
        got_result = '{value: res_ch.prime_value, found: res_ch.found,
                       range_error: res_ch.range_error, last: res_ch.last};
        if (expected_primes.size() == 0) begin
          note_mismatch("unexpected result", '0, got_result);
        end else begin
          want_result = expected_primes.pop_front();
          if (got_result.value !== want_result.value ||
              got_result.found !== want_result.found ||
              got_result.range_error !== want_result.range_error ||
              got_result.last !== want_result.last)
            note_mismatch("result mismatch", want_result, got_result);
        end
        if (res_ch.last) ranges_answered <= ranges_answered + 1;
      end
      if (req_ch.valid && req_ch.ready) begin
        predict_primes(req_ch.low_bound, req_ch.high_bound);
        ranges_taken <= ranges_taken + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned lo, hi, width;
    int          pick;

    // Directed ranges: bounds at the edges, empty and rejected ranges, squares of primes.
    add_range(0, 0, 0);
    add_range(0, 1, 0);
    add_range(1, 1, 0);
    add_range(2, 2, 0);
    add_range(4, 4, 0);
    add_range(49, 49, 0);
    add_range(0, 63, 0);
    add_range(2, 65, 0);
    add_range(0, 64, 0);
    add_range(5, 4, 0);
    add_range(65535, 0, 0);
    add_range(0, 65535, 0);
    add_range(65535, 65535, 1);
    add_range(65472, 65535, 0);
    add_range(65521, 65521, 0);
    add_range(65534, 65535, 0);
    add_range(65280, 65343, 0);
    add_range(24, 28, 0);
    add_range(32768, 32831, 0);
    add_range(13, 13, 0);

    for (int n = 0; n < 300; n++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        lo = $urandom_range(65535, 1);
        hi = $urandom_range(lo - 1, 0);
      end else if (pick < 18) begin
        lo = $urandom_range(65535 - SEGMENT_SIZE, 0);
        hi = lo + SEGMENT_SIZE + $urandom_range(65535 - SEGMENT_SIZE - lo, 0);
      end else begin
        lo    = (pick < 35) ? $urandom_range(300, 0) : $urandom_range(65535, 0);
        width = $urandom_range(SEGMENT_SIZE, 1);
        hi    = (lo + width - 1 > 65535) ? 65535 : lo + width - 1;
      end
      add_range(lo, hi, n == 150);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_ranges.size() != 0 || req_ch.valid || expected_primes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_primes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
